// ===== design/ltre_pkg.sv =====
// Shared types and constants for the left-to-right expression evaluator.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package ltre_pkg;

   // Default accumulator width and fixed channel field widths
   localparam int DATA_WIDTH_DEF = 32;
   localparam int CHAR_W         = 16;
   localparam int RESULT_W       = 32;

   // Character codes that the evaluator acts on
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 16'h0030;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 16'h0039;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 16'h002B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 16'h002D;
   localparam logic [CHAR_W-1:0] CHAR_STAR  = 16'h002A;
   localparam logic [CHAR_W-1:0] CHAR_SLASH = 16'h002F;

   // Pending operator encoding
   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   // Top-level sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OP_START,
      ST_OP_WAIT,
      ST_FIN_START,
      ST_FIN_WAIT,
      ST_EMIT
   } seq_state_type;

   // Arithmetic unit phases
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ADDSUB,
      PH_MUL,
      PH_DIV,
      PH_FIX,
      PH_DONE
   } alu_phase_type;

   // Command from sequencer to arithmetic unit
   typedef struct packed {
      logic   start;
      op_type op;
   } alu_cmd_type;

   // Status from arithmetic unit to sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } alu_stat_type;

endpackage

// ===== design/ltre_if.sv =====
// Valid/ready channel interfaces for the expression evaluator.
// Depends on ltre_pkg for the field widths.
`timescale 1ns / 1ps

interface ltre_req_if import ltre_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface ltre_rsp_if import ltre_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic signed [RESULT_W-1:0] result;

   modport source (output valid, output result, input ready);
   modport sink   (input valid, input result, output ready);
endinterface

// ===== design/left_to_right_expression_evaluator.sv =====
// Top level of the left-to-right expression evaluator: character decode,
// sequencer and state registers. Depends on ltre_pkg, ltre_if, ltre_alu.
//
//   channel  dir  handshake         payload
//   req_ch   in   valid / ready     char_code[15:0], last
//   rsp_ch   out  valid / ready     result[31:0] signed
//
// Digit or ignored character: taken in the idle state. An operator character applies
// the pending operator: one adder step for add or subtract; multiply and divide run
// the one-bit-per-cycle shared unit loop, divide adding a fix-up step; a zero divisor
// skips both. A last character adds one more pending-operator pass and an emit step.
// Synchronous reset clears state, accumulator, number, pending operator and rsp valid.
// A stalled rsp holds the emit step only; the result register parts the sides.
`timescale 1ns / 1ps

module left_to_right_expression_evaluator import ltre_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input logic        clock,
   input logic        reset,
   ltre_req_if.sink   req_ch,
   ltre_rsp_if.source rsp_ch
);

   seq_state_type              state_ff, state_in;
   logic [DATA_WIDTH-1:0]      acc_ff, acc_in;
   logic [DATA_WIDTH-1:0]      num_ff, num_in;
   op_type                     pend_ff, pend_in;
   op_type                     new_op_ff, new_op_in;
   logic                       last_ff, last_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [RESULT_W-1:0] rsp_result_ff, rsp_result_in;

   logic                  accept;
   logic                  is_digit;
   logic                  is_op;
   op_type                dec_op;
   logic                  out_free;
   alu_cmd_type           alu_cmd;
   alu_stat_type          alu_stat;
   logic [DATA_WIDTH-1:0] alu_result;

   // Decode the incoming character
   assign is_digit = (req_ch.char_code >= CHAR_ZERO) && (req_ch.char_code <= CHAR_NINE);

   always_comb begin
      is_op  = 1'b1;
      dec_op = OP_ADD;
      unique case (req_ch.char_code)
         CHAR_PLUS:  dec_op = OP_ADD;
         CHAR_MINUS: dec_op = OP_SUB;
         CHAR_STAR:  dec_op = OP_MUL;
         CHAR_SLASH: dec_op = OP_DIV;
         default:    is_op  = 1'b0;
      endcase
   end

   assign accept   = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_op) state_in = ST_OP_START;
               else if (req_ch.last) state_in = ST_FIN_START;
            end
         end
         ST_OP_START: state_in = ST_OP_WAIT;
         ST_OP_WAIT: begin
            if (alu_stat.done) state_in = last_ff ? ST_FIN_START : ST_IDLE;
         end
         ST_FIN_START: state_in = ST_FIN_WAIT;
         ST_FIN_WAIT:  if (alu_stat.done) state_in = ST_EMIT;
         ST_EMIT:      if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ch.ready  = 1'b0;
      alu_cmd.start = 1'b0;
      alu_cmd.op    = pend_ff;
      unique case (state_ff)
         ST_IDLE:      req_ch.ready  = 1'b1;
         ST_OP_START:  alu_cmd.start = 1'b1;
         ST_FIN_START: alu_cmd.start = 1'b1;
         default:      alu_cmd.start = 1'b0;
      endcase
   end

   // Datapath next values
   always_comb begin
      acc_in        = acc_ff;
      num_in        = num_ff;
      pend_in       = pend_ff;
      new_op_in     = new_op_ff;
      last_in       = last_ff;
      rsp_result_in = rsp_result_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;

      // take the character: digits extend the number by times ten plus digit
      if (accept) begin
         last_in   = req_ch.last;
         new_op_in = dec_op;
         if (is_digit) begin
            num_in = (num_ff << 3) + (num_ff << 1)
                   + {{(DATA_WIDTH-4){1'b0}}, req_ch.char_code[3:0]};
         end
      end

      // operator finished: it becomes the pending one
      if (state_ff == ST_OP_WAIT && alu_stat.done) begin
         acc_in  = alu_result;
         pend_in = new_op_ff;
         num_in  = '0;
      end

      if (state_ff == ST_FIN_WAIT && alu_stat.done) begin
         acc_in = alu_result;
      end

      // emit the beat and start a fresh expression
      if (state_ff == ST_EMIT && out_free) begin
         rsp_result_in = RESULT_W'(signed'(acc_ff));
         rsp_valid_in  = 1'b1;
         acc_in        = '0;
         num_in        = '0;
         pend_in       = OP_ADD;
      end
   end

   // Control and expression state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         num_ff       <= '0;
         pend_ff      <= OP_ADD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         num_ff       <= num_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      new_op_ff     <= new_op_in;
      last_ff       <= last_in;
      rsp_result_ff <= rsp_result_in;
   end

   ltre_alu #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_alu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (alu_cmd),
      .opa    (acc_ff),
      .opb    (num_ff),
      .stat   (alu_stat),
      .result (alu_result)
   );

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.result = rsp_result_ff;

   // The unit reports completion only while the sequencer waits for it
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      alu_stat.done |-> (state_ff == ST_OP_WAIT || state_ff == ST_FIN_WAIT))
      else $error("arithmetic unit finished outside a wait state");

   // No character is taken while the unit is still working
   a_idle_unit_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !alu_stat.busy)
      else $error("sequencer idle while arithmetic unit busy");

   // An emit loads the result beat and clears the expression state
   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free) |=>
         (rsp_valid_ff && acc_ff == '0 && num_ff == '0 && pend_ff == OP_ADD))
      else $error("emit did not load result or clear state");

endmodule

// ===== design/ltre_alu.sv =====
// Shared iterative arithmetic unit: add, subtract, shift-add multiply and
// restoring signed divide, all through one adder. Depends on ltre_pkg.
`timescale 1ns / 1ps

module ltre_alu import ltre_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  alu_cmd_type           cmd,
   input  logic [DATA_WIDTH-1:0] opa,
   input  logic [DATA_WIDTH-1:0] opb,
   output alu_stat_type          stat,
   output logic [DATA_WIDTH-1:0] result
);

   localparam int                CNT_W    = $clog2(DATA_WIDTH);
   localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(DATA_WIDTH - 1);

   alu_phase_type         phase_ff, phase_in;
   op_type                op_ff, op_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DATA_WIDTH-1:0] res_ff, res_in;
   logic [DATA_WIDTH-1:0] p_ff, p_in;
   logic [DATA_WIDTH-1:0] q_ff, q_in;
   logic                  neg_ff, neg_in;

   logic [DATA_WIDTH:0]   add_x;
   logic [DATA_WIDTH:0]   add_y;
   logic                  add_sub;
   logic [DATA_WIDTH+1:0] add_sum;
   logic [DATA_WIDTH-1:0] mag_a;
   logic [DATA_WIDTH-1:0] mag_b;

   // Magnitudes of the operands for the divide
   assign mag_a = opa[DATA_WIDTH-1] ? (~opa + 1'b1) : opa;
   assign mag_b = opb[DATA_WIDTH-1] ? (~opb + 1'b1) : opb;

   // Shared adder; top bit is the carry, set when x >= y on a subtract
   assign add_sum = {1'b0, add_x} + {1'b0, add_y ^ {(DATA_WIDTH+1){add_sub}}}
                  + (DATA_WIDTH+2)'(add_sub);

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (cmd.start) begin
               unique case (cmd.op)
                  OP_MUL:  phase_in = PH_MUL;
                  OP_DIV:  phase_in = (opb == '0) ? PH_DONE : PH_DIV;
                  default: phase_in = PH_ADDSUB;
               endcase
            end
         end
         PH_ADDSUB: phase_in = PH_DONE;
         PH_MUL:    if (cnt_ff == CNT_LAST) phase_in = PH_DONE;
         PH_DIV:    if (cnt_ff == CNT_LAST) phase_in = PH_FIX;
         PH_FIX:    phase_in = PH_DONE;
         PH_DONE:   phase_in = PH_IDLE;
         default:   phase_in = PH_IDLE;
      endcase
   end

   // Status and adder operand selection
   always_comb begin
      stat.busy = (phase_ff != PH_IDLE);
      stat.done = (phase_ff == PH_DONE);
      add_x     = '0;
      add_y     = '0;
      add_sub   = 1'b0;
      unique case (phase_ff)
         PH_ADDSUB: begin
            add_x   = {1'b0, q_ff};
            add_y   = {1'b0, p_ff};
            add_sub = (op_ff == OP_SUB);
         end
         PH_MUL: begin
            add_x = {1'b0, res_ff};
            add_y = {1'b0, p_ff};
         end
         PH_DIV: begin
            add_x   = {res_ff, q_ff[DATA_WIDTH-1]};
            add_y   = {1'b0, p_ff};
            add_sub = 1'b1;
         end
         PH_FIX: begin
            add_y   = {1'b0, q_ff};
            add_sub = neg_ff;
         end
         default: begin
            add_x = '0;
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      op_in  = op_ff;
      cnt_in = cnt_ff;
      res_in = res_ff;
      p_in   = p_ff;
      q_in   = q_ff;
      neg_in = neg_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (cmd.start) begin
               op_in  = cmd.op;
               cnt_in = '0;
               res_in = '0;
               neg_in = opa[DATA_WIDTH-1] ^ opb[DATA_WIDTH-1];
               case (cmd.op)
                  OP_MUL: begin
                     q_in = opb;
                     p_in = opa;
                  end
                  OP_DIV: begin
                     q_in = mag_a;
                     p_in = mag_b;
                     // divide by zero leaves the dividend
                     if (opb == '0) res_in = opa;
                  end
                  default: begin
                     q_in = opa;
                     p_in = opb;
                  end
               endcase
            end
         end
         PH_ADDSUB: res_in = add_sum[DATA_WIDTH-1:0];
         PH_MUL: begin
            if (q_ff[0]) res_in = add_sum[DATA_WIDTH-1:0];
            p_in   = p_ff << 1;
            q_in   = q_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
         end
         PH_DIV: begin
            // keep the trial difference when it did not borrow
            if (add_sum[DATA_WIDTH+1]) res_in = add_sum[DATA_WIDTH-1:0];
            else res_in = {res_ff[DATA_WIDTH-2:0], q_ff[DATA_WIDTH-1]};
            q_in   = {q_ff[DATA_WIDTH-2:0], add_sum[DATA_WIDTH+1]};
            cnt_in = cnt_ff + 1'b1;
         end
         PH_FIX: res_in = add_sum[DATA_WIDTH-1:0];
         default: begin
            res_in = res_ff;
         end
      endcase
   end

   // Phase register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // Operand and result registers
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      res_ff <= res_in;
      p_ff   <= p_in;
      q_ff   <= q_in;
      neg_ff <= neg_in;
   end

   assign result = res_ff;

endmodule

// ===== verif/left_to_right_expression_evaluator_tb.sv =====
// Self-checking bench for the left-to-right expression evaluator: directed and random character
// streams, with a scoreboard that evaluates each expression on its own and compares the results.
// Depends on ltre_pkg, ltre_if and the evaluator top level.
`timescale 1ns / 1ps

module left_to_right_expression_evaluator_tb import ltre_pkg::*;;

   localparam int DW            = 32;
   localparam int TARGET_ITEMS  = 900;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 2 * DW + 16;
   localparam int PRINT_CAP     = 40;

   // Evaluates expressions left to right and holds the results still owed by the block
   class expr_scoreboard;
      logic [DW-1:0]              running_total;
      logic [DW-1:0]              number_reg;
      op_type                     pending_op;
      logic signed [RESULT_W-1:0] expected_values[$];
      int                         mismatches;
      int                         results_checked;
      int                         exprs_ended;

      function new();
         clear();
         mismatches      = 0;
         results_checked = 0;
         exprs_ended     = 0;
      endfunction

      function void clear();
         running_total = '0;
         number_reg    = '0;
         pending_op    = OP_ADD;
      endfunction

      // Truncate toward zero; a zero divisor leaves the dividend as is
      function logic [DW-1:0] trunc_div(logic [DW-1:0] a, logic [DW-1:0] b);
         logic [DW-1:0] mag_a;
         logic [DW-1:0] mag_b;
         logic [DW-1:0] quot;
         mag_a = a[DW-1] ? -a : a;
         mag_b = b[DW-1] ? -b : b;
         if (mag_b == '0) begin
            return a;
         end
         quot = mag_a / mag_b;
         if (a[DW-1] ^ b[DW-1]) begin
            quot = -quot;
         end
         return quot;
      endfunction

      function void apply_pending();
         case (pending_op)
            OP_ADD:  running_total = running_total + number_reg;
            OP_SUB:  running_total = running_total - number_reg;
            OP_MUL:  running_total = running_total * number_reg;
            default: running_total = trunc_div(running_total, number_reg);
         endcase
      endfunction

      // Advance the evaluation by one accepted character
      function void note_char(logic [CHAR_W-1:0] code, logic is_last);
         op_type next_op;
         logic   is_op;
         next_op = OP_ADD;
         is_op   = 1'b1;
         if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
            number_reg = number_reg * DW'(10) + DW'(code - CHAR_ZERO);
         end else begin
            case (code)
               CHAR_PLUS:  next_op = OP_ADD;
               CHAR_MINUS: next_op = OP_SUB;
               CHAR_STAR:  next_op = OP_MUL;
               CHAR_SLASH: next_op = OP_DIV;
               default:    is_op = 1'b0;
            endcase
            if (is_op) begin
               apply_pending();
               pending_op = next_op;
               number_reg = '0;
            end
         end
         // Close the expression: fold in the pending operator and owe one result
         if (is_last) begin
            apply_pending();
            expected_values.push_back(RESULT_W'(signed'(running_total)));
            clear();
            exprs_ended++;
         end
      endfunction

      task report(string msg);
         if (mismatches < PRINT_CAP) begin
            $display("%0t ns  ERROR: %s", $time, msg);
         end
         mismatches++;
      endtask

      task check_result(logic signed [RESULT_W-1:0] got);
         logic signed [RESULT_W-1:0] want;
         if (expected_values.size() == 0) begin
            report($sformatf("result %0d with no expression outstanding", got));
         end else begin
            want = expected_values.pop_front();
            results_checked++;
            if (got !== want) begin
               report($sformatf("result %0d, predicted %0d", got, want));
            end
         end
      endtask
   endclass

   logic clock;
   logic reset;
   int   cycle_count;
   int   send_idle_pct;
   int   rsp_stall_pct;
   int   active_items;
   int   chars_sent;

   string             corner_values[5] = '{"0", "1", "2147483647", "2147483648", "4294967295"};
   logic [CHAR_W-1:0] op_chars[4]      = '{CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH};

   expr_scoreboard sb;

   ltre_req_if req_ch ();
   ltre_rsp_if rsp_ch ();

   left_to_right_expression_evaluator #(
      .DATA_WIDTH(DW)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("left_to_right_expression_evaluator: mismatch");
         $finish;
      end
   end

   // Stall the result side at random
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Watch both channels: note accepted characters, check accepted results
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            sb.note_char(req_ch.char_code, req_ch.last);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            sb.check_result(rsp_ch.result);
         end
      end
   end

   function automatic logic acts_on(logic [CHAR_W-1:0] code);
      return (code >= CHAR_ZERO && code <= CHAR_NINE) || code == CHAR_PLUS ||
             code == CHAR_MINUS || code == CHAR_STAR || code == CHAR_SLASH;
   endfunction

   // Any code the block ignores, spaces most often
   function automatic logic [CHAR_W-1:0] noise_char();
      logic [CHAR_W-1:0] code;
      if ($urandom_range(0, 2) == 0) begin
         return 16'h0020;
      end
      code = CHAR_ZERO;
      while (acts_on(code)) begin
         code = CHAR_W'($urandom_range(0, 65535));
      end
      return code;
   endfunction

   function automatic logic [CHAR_W-1:0] random_char();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return CHAR_ZERO + CHAR_W'($urandom_range(0, 9));
         4, 5, 6:    return op_chars[$urandom_range(0, 3)];
         default:    return noise_char();
      endcase
   endfunction

   // Mostly small numbers, with corner values, overflowing digit runs and empty operands
   function automatic string random_operand();
      string s;
      s = "";
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: s = $sformatf("%0d", $urandom_range(0, 99));
         5: s = $sformatf("%0d", $urandom_range(0, 99999));
         6: s = corner_values[$urandom_range(0, 4)];
         7: repeat ($urandom_range(10, 12)) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
         8: s = $sformatf("%0d", $urandom_range(1, 9));
         default: s = "";
      endcase
      return s;
   endfunction

   // Present one character and hold it until accepted; keep valid high into the next beat
   task automatic send_char(logic [CHAR_W-1:0] code, logic is_last);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_ch.valid     <= 1'b1;
      req_ch.char_code <= code;
      req_ch.last      <= is_last;
      do @(posedge clock); while (!req_ch.ready);
      chars_sent++;
      if (is_last || acts_on(code)) begin
         active_items++;
      end
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) begin
         send_char({8'h00, s[i]}, i == s.len() - 1);
      end
   endtask

   // One expression: mostly well formed with noise mixed in, sometimes a free jumble
   task automatic random_expression();
      logic [CHAR_W-1:0] codes[$];
      int                n_terms;
      string             term;
      if ($urandom_range(0, 99) < 15) begin
         repeat ($urandom_range(1, 8)) codes.push_back(random_char());
      end else begin
         n_terms = $urandom_range(1, 5);
         for (int t = 0; t < n_terms; t++) begin
            if (t > 0) begin
               codes.push_back(op_chars[$urandom_range(0, 3)]);
            end
            term = random_operand();
            for (int i = 0; i < term.len(); i++) begin
               codes.push_back({8'h00, term[i]});
            end
            if ($urandom_range(0, 9) == 0) begin
               codes.push_back(noise_char());
            end
         end
         // Trailing operator now and then
         if ($urandom_range(0, 9) == 0) begin
            codes.push_back(op_chars[$urandom_range(0, 3)]);
         end
      end
      foreach (codes[i]) begin
         send_char(codes[i], i == codes.size() - 1);
      end
   endtask

   initial begin
      sb = new();
      cycle_count   = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      active_items  = 0;
      chars_sent    = 0;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.char_code <= '0;
      req_ch.last      <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Ignored codes at both extremes, the second one ending an empty expression
      send_char(16'hFFFF, 1'b0);
      send_char(16'h0000, 1'b1);
      // Every operator, with division by zero at the end
      send_text("7+5*3-1/0");
      // Trailing operator, truncating division of a negative value, ignored last character
      send_text("8-");
      send_text("-7/2");
      send_text("3*4 ");
      // Wraparound: most negative over minus one, digit overflow, product overflow
      send_text("2147483648/4294967295");
      send_text("99999999999");
      send_text("65536*65536+2147483647+1");

      // Random phases: no idling, sender gaps, receiver stalls, both
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 48; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 48; end
            default: begin send_idle_pct = 21; rsp_stall_pct = 21; end
         endcase
         while (active_items < (p + 1) * TARGET_ITEMS / 4) begin
            random_expression();
         end
      end
      req_ch.valid <= 1'b0;

      // Drain outstanding results, then let the block settle
      while (sb.expected_values.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.expected_values.size() != 0) begin
         sb.report($sformatf("%0d results never arrived", sb.expected_values.size()));
      end

      $display("Sent %0d characters (%0d acted on) in %0d expressions under four idle patterns;",
               chars_sent, active_items, sb.exprs_ended);
      $display("compared %0d results, %0d errors.", sb.results_checked, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("left_to_right_expression_evaluator: match");
      end else begin
         $display("left_to_right_expression_evaluator: mismatch");
      end
      $finish;
   end

endmodule
